// ===== rtl/sktq_pkg.sv =====
// Shared types, sizes and codes for the sorted key priority queue.
`default_nettype none

package sktq_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_W    = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [FIELD_W-1:0]      item_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT    = 3'd0,
        FUNC_PREPEND   = 3'd1,
        FUNC_APPEND    = 3'd2,
        FUNC_REM_FIRST = 3'd3,
        FUNC_REM_KEY   = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_INS_SORT  = 3'd1,
        OP_INS_FRONT = 3'd2,
        OP_INS_BACK  = 3'd3,
        OP_REM_FIRST = 3'd4,
        OP_REM_KEY   = 3'd5
    } op_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic  en;
        op_t   op;
        key_t  req_key;
        key_t  new_key;
        item_t item;
    } cmd_t;

    // Contents of one cell, as seen by its neighbours.
    typedef struct packed {
        logic  valid;
        key_t  key;
        item_t item;
    } slot_t;

    // Flags and reductions that ripple from cell 0 towards the last cell.
    typedef struct packed {
        logic  prior;
        key_t  sel_key;
        item_t sel_item;
        key_t  tail_key;
    } chain_t;

endpackage

`default_nettype wire

// ===== rtl/sktq_req_if.sv =====
// Request channel: one queue operation per beat.
`default_nettype none

interface sktq_req_if;
    logic                                valid;
    logic                                ready;
    logic [sktq_pkg::FUNC_W-1:0]         func;
    logic signed [sktq_pkg::FIELD_W-1:0] req_key;
    logic [sktq_pkg::FIELD_W-1:0]        req_item;

    modport source (output valid, output func, output req_key, output req_item, input ready);
    modport sink   (input valid, input func, input req_key, input req_item, output ready);
endinterface

`default_nettype wire

// ===== rtl/sktq_rsp_if.sv =====
// Response channel: one status beat per operation.
`default_nettype none

interface sktq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sktq_pkg::STATUS_W-1:0]       status;
    logic signed [sktq_pkg::FIELD_W-1:0] out_key;
    logic [sktq_pkg::FIELD_W-1:0]        out_item;

    modport source (output valid, output status, output out_key, output out_item, input ready);
    modport sink   (input valid, input status, input out_key, input out_item, output ready);
endinterface

`default_nettype wire

// ===== rtl/sktq_cell.sv =====
// One storage cell of the sorted row, with its shift and search logic.
`default_nettype none

module sktq_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sktq_pkg::cmd_t   cmd,
    input  wire sktq_pkg::slot_t  left_slot,
    input  wire sktq_pkg::slot_t  right_slot,
    input  wire sktq_pkg::chain_t chain_in,
    output sktq_pkg::chain_t      chain_out,
    output sktq_pkg::slot_t       slot
);

    logic              valid_reg;
    logic              valid_next;
    sktq_pkg::key_t    key_reg;
    sktq_pkg::key_t    key_next;
    sktq_pkg::item_t   item_reg;
    sktq_pkg::item_t   item_next;
    logic              hit;
    logic              here;
    logic              is_last;

    assign slot.valid = valid_reg;
    assign slot.key   = key_reg;
    assign slot.item  = item_reg;

    always_comb
    begin
        case (cmd.op)
            sktq_pkg::OP_INS_SORT:  hit = !valid_reg || (key_reg >= cmd.req_key);
            sktq_pkg::OP_INS_FRONT: hit = 1'b1;
            sktq_pkg::OP_INS_BACK:  hit = !valid_reg;
            sktq_pkg::OP_REM_FIRST: hit = 1'b1;
            sktq_pkg::OP_REM_KEY:   hit = valid_reg && (key_reg == cmd.req_key);
            default:                hit = 1'b0;
        endcase
    end

    // Only the leftmost hit in the row is the working position.
    assign here    = hit && !chain_in.prior;
    assign is_last = valid_reg && !right_slot.valid;

    always_comb
    begin
        chain_out.prior    = chain_in.prior || hit;
        chain_out.sel_key  = chain_in.sel_key | ((here && valid_reg) ? key_reg : '0);
        chain_out.sel_item = chain_in.sel_item | ((here && valid_reg) ? item_reg : '0);
        chain_out.tail_key = chain_in.tail_key | (is_last ? key_reg : '0);
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        item_next  = item_reg;
        if (cmd.en)
        begin
            case (cmd.op)
                sktq_pkg::OP_INS_SORT, sktq_pkg::OP_INS_FRONT, sktq_pkg::OP_INS_BACK:
                begin
                    if (chain_in.prior)
                    begin
                        valid_next = left_slot.valid;
                        key_next   = left_slot.key;
                        item_next  = left_slot.item;
                    end
                    else if (hit)
                    begin
                        valid_next = 1'b1;
                        key_next   = cmd.new_key;
                        item_next  = cmd.item;
                    end
                end
                sktq_pkg::OP_REM_FIRST, sktq_pkg::OP_REM_KEY:
                begin
                    if (chain_in.prior || hit)
                    begin
                        valid_next = right_slot.valid;
                        key_next   = right_slot.key;
                        item_next  = right_slot.item;
                    end
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_key_priority_queue_unit.sv =====
// Top level of the sorted key priority queue: command decode, cell row and result register.
//
//  Channel | Modport | Payload                      | Beat
//  req     | sink    | func, req_key, req_item      | one queue operation
//  rsp     | source  | status, out_key, out_item    | one result per operation
//
// Every operation completes in the cycle it is accepted; its result beat is
// registered and shown on rsp from the next cycle, one operation per cycle
// unless rsp stalls. The limit is the ripple through the DEPTH cells
// (position search and result selection) plus a key decrement for prepend
// or increment for append. Reset clears all valid bits (cells and result);
// a stall loses no item, as req.ready falls until the held beat is taken.
`default_nettype none

module sorted_key_priority_queue_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sktq_req_if.sink     req,
    sktq_rsp_if.source   rsp
);

    sktq_pkg::cmd_t   cmd;
    sktq_pkg::slot_t  slot_w  [sktq_pkg::DEPTH];
    sktq_pkg::slot_t  left_w  [sktq_pkg::DEPTH];
    sktq_pkg::slot_t  right_w [sktq_pkg::DEPTH];
    sktq_pkg::chain_t chain_w [sktq_pkg::DEPTH+1];

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 found;
    sktq_pkg::key_t       rkey;
    sktq_pkg::status_t    status_c;
    sktq_pkg::key_t       okey_c;
    sktq_pkg::item_t      oitem_c;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    sktq_pkg::status_t    status_reg;
    sktq_pkg::key_t       key_reg;
    sktq_pkg::item_t      item_reg;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign rkey  = sktq_pkg::key_t'(req.req_key);
    assign full  = slot_w[sktq_pkg::DEPTH-1].valid;
    assign empty = !slot_w[0].valid;
    assign found = chain_w[sktq_pkg::DEPTH].prior;

    always_comb
    begin
        cmd.en      = 1'b0;
        cmd.op      = sktq_pkg::OP_NONE;
        cmd.req_key = rkey;
        cmd.new_key = rkey;
        cmd.item    = req.req_item;
        status_c    = sktq_pkg::ST_OK;
        okey_c      = '0;
        oitem_c     = '0;
        case (req.func)
            sktq_pkg::FUNC_INSERT:
            begin
                cmd.op   = sktq_pkg::OP_INS_SORT;
                cmd.en   = accept && !full;
                status_c = full ? sktq_pkg::ST_FULL : sktq_pkg::ST_OK;
            end
            sktq_pkg::FUNC_PREPEND:
            begin
                cmd.op      = sktq_pkg::OP_INS_FRONT;
                cmd.new_key = empty ? '0 : slot_w[0].key - sktq_pkg::key_t'(1);
                cmd.en      = accept && !full;
                status_c    = full ? sktq_pkg::ST_FULL : sktq_pkg::ST_OK;
            end
            sktq_pkg::FUNC_APPEND:
            begin
                cmd.op      = sktq_pkg::OP_INS_BACK;
                cmd.new_key = empty ? '0
                                    : chain_w[sktq_pkg::DEPTH].tail_key + sktq_pkg::key_t'(1);
                cmd.en      = accept && !full;
                status_c    = full ? sktq_pkg::ST_FULL : sktq_pkg::ST_OK;
            end
            sktq_pkg::FUNC_REM_FIRST:
            begin
                cmd.op = sktq_pkg::OP_REM_FIRST;
                cmd.en = accept && !empty;
                if (empty)
                    status_c = sktq_pkg::ST_EMPTY;
                else
                begin
                    okey_c  = chain_w[sktq_pkg::DEPTH].sel_key;
                    oitem_c = chain_w[sktq_pkg::DEPTH].sel_item;
                end
            end
            sktq_pkg::FUNC_REM_KEY:
            begin
                cmd.op = sktq_pkg::OP_REM_KEY;
                cmd.en = accept && !empty && found;
                if (empty)
                    status_c = sktq_pkg::ST_EMPTY;
                else if (!found)
                    status_c = sktq_pkg::ST_NOT_FOUND;
                else
                begin
                    okey_c  = chain_w[sktq_pkg::DEPTH].sel_key;
                    oitem_c = chain_w[sktq_pkg::DEPTH].sel_item;
                end
            end
            default:
            begin
                cmd.op = sktq_pkg::OP_NONE;
            end
        endcase
    end

    assign chain_w[0] = '0;

    for (genvar i = 0; i < sktq_pkg::DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_w[i] = '0;
        end
        else
        begin : g_mid_l
            assign left_w[i] = slot_w[i-1];
        end
        if (i == sktq_pkg::DEPTH-1)
        begin : g_last
            assign right_w[i] = '0;
        end
        else
        begin : g_mid_r
            assign right_w[i] = slot_w[i+1];
        end

        sktq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_slot  (left_w[i]),
            .right_slot (right_w[i]),
            .chain_in   (chain_w[i]),
            .chain_out  (chain_w[i+1]),
            .slot       (slot_w[i])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_c;
            key_reg    <= okey_c;
            item_reg   <= oitem_c;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.out_key  = sktq_pkg::FIELD_W'(key_reg);
    assign rsp.out_item = item_reg;

endmodule

`default_nettype wire

// ===== rtl/sktq_checker.sv =====
// Port-level checks on the sorted key priority queue, bound to its top level.
`default_nettype none

module sktq_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                req_valid,
    input wire logic                                req_ready,
    input wire logic                                rsp_valid,
    input wire logic                                rsp_ready,
    input wire logic [sktq_pkg::STATUS_W-1:0]       status,
    input wire logic signed [sktq_pkg::FIELD_W-1:0] out_key,
    input wire logic [sktq_pkg::FIELD_W-1:0]        out_item
);

    // A held result beat must not change until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
                                    && $stable(out_key) && $stable(out_item))
        else $error("response beat changed while stalled");

    // Every accepted operation produces a result beat in the next cycle.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted operation gave no result beat");

    // The request side is open exactly when the result slot is free or draining.
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("request ready does not follow the result slot");

    // Failure statuses carry no entry.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != sktq_pkg::ST_OK |-> out_key == '0 && out_item == '0)
        else $error("failed operation returned a non-zero entry");

endmodule

bind sorted_key_priority_queue_unit sktq_checker u_sktq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .out_key   (rsp.out_key),
    .out_item  (rsp.out_item)
);

`default_nettype wire
